>>> rtl/tpe_pkg.sv
// shared types, widths and iteration steps for the triangle plane unit
// used by tpe_sqrt, tpe_div and triangle_plane_equation; no dependencies
package tpe_pkg;

    // fixed widths of the normalization path, independent of coordinate width
    localparam int MAG_W    = 31;   // scaled cross product magnitude
    localparam int SUMSQ_W  = 64;   // sum of squares
    localparam int ROOT_W   = 32;   // floor square root
    localparam int SQREM_W  = 35;   // square root partial remainder
    localparam int NUM_W    = 62;   // dividend of the normal division
    localparam int QUO_W    = 32;   // quotient bits produced
    localparam int DVREM_W  = 33;   // division partial remainder
    localparam int NRM_W    = 32;   // normal component, Q2.30
    localparam int NRM_FRAC = 30;
    localparam int STAGES   = 16;   // pipeline stages of each iterative unit

    // square root state: remainder, root so far, radicand still to consume
    typedef struct packed {
        logic [SQREM_W-1:0] rem;
        logic [ROOT_W-1:0]  root;
        logic [SUMSQ_W-1:0] rad;
    } t_sq_st;

    // division state: remainder, quotient so far, low dividend bits left
    typedef struct packed {
        logic [DVREM_W-1:0] rem;
        logic [QUO_W-1:0]   quo;
        logic [QUO_W-1:0]   num;
    } t_dv_st;

    // one digit of the bit-pair square root
    function automatic t_sq_st sq_step(t_sq_st s);
        t_sq_st             r;
        logic [SQREM_W-1:0] acc;
        logic [SQREM_W-1:0] trial;
        acc   = {s.rem[SQREM_W-3:0], s.rad[SUMSQ_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[SUMSQ_W-3:0], 2'b00};
        if (acc >= trial) begin
            r.rem  = acc - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = acc;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one bit of restoring division
    function automatic t_dv_st dv_step(t_dv_st s, logic [ROOT_W-1:0] den);
        t_dv_st             r;
        logic [DVREM_W-1:0] acc;
        acc   = {s.rem[DVREM_W-2:0], s.num[QUO_W-1]};
        r.num = {s.num[QUO_W-2:0], 1'b0};
        if (acc >= {1'b0, den}) begin
            r.rem = acc - {1'b0, den};
            r.quo = {s.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = acc;
            r.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> rtl/tpe_sqrt.sv
// pipelined floor square root of a 64-bit value, two digits per stage
// depends on tpe_pkg (state type and step function)
module tpe_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [tpe_pkg::SUMSQ_W-1:0]   i_radicand,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [tpe_pkg::ROOT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);
    import tpe_pkg::*;

    t_sq_st            r_st   [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];
    logic              r_vld  [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_sq_st            cur;
        t_sq_st            n_st;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;

        // stage input: the port for the first stage, else the stage before
        if (g == 0) begin : g_first
            always_comb begin
                cur.rem  = '0;
                cur.root = '0;
                cur.rad  = i_radicand;
                cur_side = i_side;
                cur_vld  = i_valid;
            end
        end else begin : g_next
            always_comb begin
                cur      = r_st[g-1];
                cur_side = r_side[g-1];
                cur_vld  = r_vld[g-1];
            end
        end

        // two root digits
        always_comb begin
            n_st = sq_step(sq_step(cur));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g]   <= n_st;
                r_side[g] <= cur_side;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_root  = r_st[STAGES-1].root;
    assign o_side  = r_side[STAGES-1];

endmodule

>>> rtl/tpe_div.sv
// three-lane pipelined restoring divider sharing one divisor, two bits per stage
// depends on tpe_pkg (state type and step function)
module tpe_div #(
    parameter int SIDE_W = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [2:0][tpe_pkg::NUM_W-1:0]       i_num,
    input  logic [tpe_pkg::ROOT_W-1:0]           i_den,
    input  logic [SIDE_W-1:0]                    i_side,
    output logic                                 o_valid,
    output logic [2:0][tpe_pkg::QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]                    o_side
);
    import tpe_pkg::*;

    t_dv_st [2:0]      r_st   [STAGES];
    logic [ROOT_W-1:0] r_den  [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];
    logic              r_vld  [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_dv_st [2:0]      cur;
        t_dv_st [2:0]      n_st;
        logic [ROOT_W-1:0] cur_den;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;

        // stage input; the quotient fits 32 bits, so the top dividend bits
        // already form a remainder below the divisor
        if (g == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    cur[l].rem = {{(DVREM_W-NUM_W+QUO_W){1'b0}}, i_num[l][NUM_W-1:QUO_W]};
                    cur[l].quo = '0;
                    cur[l].num = i_num[l][QUO_W-1:0];
                end
                cur_den  = i_den;
                cur_side = i_side;
                cur_vld  = i_valid;
            end
        end else begin : g_next
            always_comb begin
                cur      = r_st[g-1];
                cur_den  = r_den[g-1];
                cur_side = r_side[g-1];
                cur_vld  = r_vld[g-1];
            end
        end

        // two quotient bits per lane
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_st[l] = dv_step(dv_step(cur[l], cur_den), cur_den);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g]   <= n_st;
                r_den[g]  <= cur_den;
                r_side[g] <= cur_side;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_st[STAGES-1][l].quo;
        end
    end

endmodule

>>> rtl/triangle_plane_equation.sv
// top level of the triangle plane unit: cross product, normalization, offset
// depends on tpe_pkg, tpe_sqrt and tpe_div
//
// Usage: one triangle per input transfer on the slave stream, one plane per
// output transfer on the master stream. Vertex a, pivot b and c arrive as
// signed fixed point; the result is a unit normal in Q2.30 and the offset
// d = -(n . a) in the coordinate format, rounded half up and saturated.
// tuser flags a zero cross product (all fields zero) and a clipped offset.
// The pipeline has 7 stages of cross product, scaling and sum of squares,
// 16 stages of square root (two digits each), 1 dividend stage,
// 16 stages of division (two bits each) and 4 stages of offset arithmetic.
// Throughput is one triangle per cycle while the output is not stalled;
// every stage is registered, iterative units unrolled into pipeline stages.
// Reset clears all valid bits, so the pipeline comes up empty.
// When the receiver stalls a held output, the whole pipeline holds and
// o_s_tready drops, even while stages ahead of the output are empty.
module triangle_plane_equation #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // normal_x, normal_y, normal_z, plane_offset, zero fill
    output logic [((3*32+COORD_WIDTH+7)/8)*8-1:0]  o_m_tdata,
    // degenerate, offset_saturated
    output logic [1:0]                             o_m_tuser
);
    import tpe_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int OUT_W  = ((3*NRM_W+W+7)/8)*8;
    localparam int MW     = 2*W+2;             // cross product magnitude
    localparam int TOP_W  = $clog2(MW+1);
    localparam int TW     = W+34;              // dot product sum
    localparam int SQS_W  = 1+3+3*W+3*MAG_W;   // side data through the root
    localparam int DVS_W  = 1+3+3*W;           // side data through the divider

    logic en;

    // stage 1: edge vectors
    logic              r1_vld;
    logic signed [W:0] r1_u [3];
    logic signed [W:0] r1_v [3];
    logic [W-1:0]      r1_a [3];
    // stage 2: partial products
    logic                  r2_vld;
    logic signed [2*W+1:0] r2_pp [3];
    logic signed [2*W+1:0] r2_pn [3];
    logic [W-1:0]          r2_a  [3];
    // stage 3: cross product as sign and magnitude
    logic          r3_vld;
    logic [MW-1:0] r3_mag [3];
    logic [2:0]    r3_neg;
    logic [W-1:0]  r3_a   [3];
    // stage 4: bit length of the largest component
    logic             r4_vld;
    logic [MW-1:0]    r4_mag [3];
    logic [TOP_W-1:0] r4_top;
    logic [2:0]       r4_neg;
    logic [W-1:0]     r4_a   [3];
    // stage 5: scaled magnitudes
    logic             r5_vld;
    logic [MAG_W-1:0] r5_mag [3];
    logic             r5_degen;
    logic [2:0]       r5_neg;
    logic [W-1:0]     r5_a   [3];
    // stage 6: squares
    logic               r6_vld;
    logic [2*MAG_W-1:0] r6_sq [3];
    logic [SQS_W-1:0]   r6_side;
    // stage 7: sum of squares
    logic               r7_vld;
    logic [SUMSQ_W-1:0] r7_sum;
    logic [SQS_W-1:0]   r7_side;
    // square root output
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    logic [SQS_W-1:0]  sq_side;
    // stage 8: dividends
    logic                  r8_vld;
    logic [2:0][NUM_W-1:0] r8_num;
    logic [ROOT_W-1:0]     r8_den;
    logic [DVS_W-1:0]      r8_side;
    // divider output
    logic                  dv_vld;
    logic [2:0][QUO_W-1:0] dv_quo;
    logic [DVS_W-1:0]      dv_side;
    // stage 9: signed normal
    logic                    r9_vld;
    logic signed [NRM_W-1:0] r9_nrm [3];
    logic                    r9_degen;
    logic [W-1:0]            r9_a   [3];
    // stage 10: dot product terms
    logic                      r10_vld;
    logic signed [NRM_W+W-1:0] r10_prod [3];
    logic [NRM_W-1:0]          r10_nrm  [3];
    logic                      r10_degen;
    // stage 11: dot product
    logic                 r11_vld;
    logic signed [TW-1:0] r11_t;
    logic [NRM_W-1:0]     r11_nrm [3];
    logic                 r11_degen;
    // stage 12: output register
    logic             r12_vld;
    logic [NRM_W-1:0] r12_nrm [3];
    logic [W-1:0]     r12_off;
    logic             r12_degen;
    logic             r12_sat;

    logic [MW:0]      n3_diff [3];
    logic [MW-1:0]    or_mag;
    logic [TOP_W-1:0] n4_top;
    logic [MW+MAG_W-1:0] n5_wide [3];
    logic signed [TW-1:0] n12_r;
    logic signed [W+3:0]  n12_sh;
    logic                 n12_ovf;

    // one global advance: the output register is free or being drained
    assign en         = !r12_vld || i_m_tready;
    assign o_s_tready = en;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
        end else if (en) begin
            r1_vld  <= i_s_tvalid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= sq_vld;
            r9_vld  <= dv_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
        end
    end

    // cross product helpers
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_diff[i] = (MW+1)'(r2_pp[i]) - (MW+1)'(r2_pn[i]);
        end
        or_mag = r3_mag[0] | r3_mag[1] | r3_mag[2];
        n4_top = '0;
        for (int j = 0; j < MW; j++) begin
            if (or_mag[j]) begin
                n4_top = TOP_W'(j + 1);
            end
        end
        // floor(mag * 2^(31 - top)) as one right shift
        for (int i = 0; i < 3; i++) begin
            n5_wide[i] = {r4_mag[i], {MAG_W{1'b0}}} >> r4_top;
        end
    end

    // stages 1 to 7: edges, products, cross product, scaling, squares, sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_u[i] <= $signed(i_s_tdata[i*W +: W]) - $signed(i_s_tdata[(3+i)*W +: W]);
                r1_v[i] <= $signed(i_s_tdata[(6+i)*W +: W]) - $signed(i_s_tdata[(3+i)*W +: W]);
                r1_a[i] <= i_s_tdata[i*W +: W];

                r2_pp[i] <= r1_u[(i+1)%3] * r1_v[(i+2)%3];
                r2_pn[i] <= r1_u[(i+2)%3] * r1_v[(i+1)%3];
                r2_a[i]  <= r1_a[i];

                r3_neg[i] <= n3_diff[i][MW];
                r3_mag[i] <= n3_diff[i][MW] ? MW'(-n3_diff[i]) : n3_diff[i][MW-1:0];
                r3_a[i]   <= r2_a[i];

                r4_mag[i] <= r3_mag[i];
                r4_a[i]   <= r3_a[i];

                r5_mag[i] <= n5_wide[i][MAG_W-1:0];
                r5_a[i]   <= r4_a[i];

                r6_sq[i]  <= r5_mag[i] * r5_mag[i];
            end
            r4_top   <= n4_top;
            r4_neg   <= r3_neg;
            r5_neg   <= r4_neg;
            r5_degen <= (r4_top == '0);
            r6_side  <= {r5_degen, r5_neg, r5_a[2], r5_a[1], r5_a[0],
                         r5_mag[2], r5_mag[1], r5_mag[0]};
            r7_sum   <= SUMSQ_W'(r6_sq[0]) + SUMSQ_W'(r6_sq[1]) + SUMSQ_W'(r6_sq[2]);
            r7_side  <= r6_side;
        end
    end

    tpe_sqrt #(
        .SIDE_W (SQS_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r7_vld),
        .i_radicand (r7_sum),
        .i_side     (r7_side),
        .o_valid    (sq_vld),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // stage 8: mag * 2^30 plus half the length, rounding the quotient
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_num[i] <= {sq_side[i*MAG_W +: MAG_W], {NRM_FRAC{1'b0}}}
                           + NUM_W'(sq_root >> 1);
            end
            r8_den  <= sq_root;
            r8_side <= sq_side[SQS_W-1:3*MAG_W];
        end
    end

    tpe_div #(
        .SIDE_W (DVS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_vld),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_side  (r8_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // offset rounding and saturation
    always_comb begin
        n12_r   = -r11_t + $signed({{(TW-NRM_FRAC){1'b0}}, 1'b1, {(NRM_FRAC-1){1'b0}}});
        n12_sh  = n12_r[TW-1:NRM_FRAC];
        n12_ovf = (n12_sh[W+3:W-1] != '0) && (n12_sh[W+3:W-1] != '1);
    end

    // stages 9 to 12: sign, dot product, offset
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r9_nrm[i] <= dv_side[3*W+i] ? $signed(-dv_quo[i]) : $signed(dv_quo[i]);
                r9_a[i]   <= dv_side[i*W +: W];

                r10_prod[i] <= r9_nrm[i] * $signed(r9_a[i]);
                r10_nrm[i]  <= r9_nrm[i];

                r11_nrm[i]  <= r10_nrm[i];

                r12_nrm[i]  <= r11_degen ? '0 : r11_nrm[i];
            end
            r9_degen  <= dv_side[DVS_W-1];
            r10_degen <= r9_degen;
            r11_t     <= TW'(r10_prod[0]) + TW'(r10_prod[1]) + TW'(r10_prod[2]);
            r11_degen <= r10_degen;
            r12_degen <= r11_degen;
            if (r11_degen) begin
                r12_off <= '0;
                r12_sat <= 1'b0;
            end else if (n12_ovf) begin
                r12_off <= {n12_sh[W+3], {(W-1){~n12_sh[W+3]}}};
                r12_sat <= 1'b1;
            end else begin
                r12_off <= n12_sh[W-1:0];
                r12_sat <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r12_vld;
    assign o_m_tdata  = OUT_W'({r12_off, r12_nrm[2], r12_nrm[1], r12_nrm[0]});
    assign o_m_tuser  = {r12_sat, r12_degen};

`ifndef ASSERT_OFF
    // a degenerate triangle gives all-zero fields and no clipping
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0 && !o_m_tuser[1]))
        else $error("degenerate result with nonzero fields");

    // a clipped offset sits at one end of the range
    a_sat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1])
        |-> (r12_off[W-2:0] == {(W-1){~r12_off[W-1]}}))
        else $error("saturated offset not at range end");

    // normal components stay within the unit range
    a_nrm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(r12_nrm[0]) <= 33'sd1073741824
                     && $signed(r12_nrm[0]) >= -33'sd1073741824
                     && $signed(r12_nrm[1]) <= 33'sd1073741824
                     && $signed(r12_nrm[1]) >= -33'sd1073741824
                     && $signed(r12_nrm[2]) <= 33'sd1073741824
                     && $signed(r12_nrm[2]) >= -33'sd1073741824))
        else $error("normal component out of range");

    // a stalled pipeline holds the item ahead of the output register
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r11_vld) |=> (r11_vld && $stable(r11_t)))
        else $error("pipeline item lost during stall");
`endif

endmodule

>>> sim/triangle_plane_equation_tb.sv
// self-checking testbench for the triangle plane unit: random and corner triangles
// are streamed in, each plane is predicted in the bench and its data and user checked
// depends on rtl/triangle_plane_equation.sv with tpe_pkg, tpe_sqrt and tpe_div
`timescale 1ns / 100ps

module triangle_plane_equation_tb;

    localparam int CW     = 32;
    localparam int TRI_W  = ((9*CW+7)/8)*8;
    localparam int PLN_W  = ((3*32+CW+7)/8)*8;
    localparam int GAP_MAX = 18;

    typedef struct {
        logic [TRI_W-1:0] data;
        bit               drain;   // wait for an empty pipeline before this one
    } t_tri_item;

    typedef struct {
        logic [PLN_W-1:0] data;
        logic [1:0]       user;
    } t_plane;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic [TRI_W-1:0]   i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    // normal_x, normal_y, normal_z, plane_offset
    logic [PLN_W-1:0]   o_m_tdata;
    // degenerate, offset_saturated
    logic [1:0]         o_m_tuser;

    t_tri_item  pending_tris[$];
    t_plane     expected_planes[$];
    int         errors = 0;
    int         n_sent = 0;
    int         n_checked = 0;
    int         n_degen = 0;
    int         n_sat = 0;
    bit         s_fire = 0;
    bit         m_fire = 0;
    bit         no_idle = 0;
    int         send_gap = 0;
    int         recv_stall = 0;

    triangle_plane_equation #(.COORD_WIDTH(CW)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // unit normal and rounded, saturated offset of one triangle
    function automatic t_plane plane_of(logic [TRI_W-1:0] tri_bits);
        logic signed [127:0] av[3], bv[3], cv[3], u[3], v[3], cr[3];
        logic signed [127:0] nrm[3], acc, r, sh;
        logic [127:0]        mg[3];
        logic [63:0]         sm[3], ssq, len, cand, q;
        logic                neg[3];
        int                  top, p, k;
        t_plane              res;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            av[i] = $signed(tri_bits[32*i +: 32]);
            bv[i] = $signed(tri_bits[32*(3+i) +: 32]);
            cv[i] = $signed(tri_bits[32*(6+i) +: 32]);
            u[i]  = av[i] - bv[i];
            v[i]  = cv[i] - bv[i];
        end
        for (int i = 0; i < 3; i++) begin
            p = (i + 1) % 3;
            k = (i + 2) % 3;
            cr[i]  = u[p] * v[k] - u[k] * v[p];
            neg[i] = cr[i] < 0;
            mg[i]  = neg[i] ? -cr[i] : cr[i];
            for (int j = 0; j < 128; j++)
                if (mg[i][j] && j + 1 > top) top = j + 1;
        end
        res.data = '0;
        res.user = 2'b00;
        if (top == 0) begin
            res.user[0] = 1'b1;
            return res;
        end
        ssq = 0;
        for (int i = 0; i < 3; i++) begin
            if (top <= 31) sm[i] = 64'(mg[i] << (31 - top));
            else sm[i] = 64'(mg[i] >> (top - 31));
            ssq = ssq + sm[i] * sm[i];
        end
        // floor square root, one bit at a time
        len = 0;
        for (int j = 31; j >= 0; j--) begin
            cand = len | (64'd1 << j);
            if (cand * cand <= ssq) len = cand;
        end
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            q      = ((sm[i] << 30) + (len >> 1)) / len;
            nrm[i] = neg[i] ? -$signed({64'd0, q}) : $signed({64'd0, q});
            res.data[32*i +: 32] = nrm[i][31:0];
            acc = acc + nrm[i] * av[i];
        end
        // negate, round half up, drop 30 fraction bits
        r  = -acc + (128'sd1 <<< 29);
        sh = r >>> 30;
        if (sh > 128'sh7FFFFFFF) begin
            res.data[96 +: 32] = 32'h7FFFFFFF;
            res.user[1] = 1'b1;
        end else if (sh < -128'sh80000000) begin
            res.data[96 +: 32] = 32'h80000000;
            res.user[1] = 1'b1;
        end else begin
            res.data[96 +: 32] = sh[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: rand_coord = $urandom;
            1: rand_coord = $urandom_range(0, 8) == 0 ? 32'h7FFFFFFF : $urandom;
            2: rand_coord = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            3: rand_coord = 32'($signed($urandom_range(0, 64)) - 32);
            default: rand_coord = $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
        endcase
    endfunction

    task automatic add_tri(input logic [31:0] c[9], input bit drain);
        t_tri_item it;
        it.data = '0;
        for (int i = 0; i < 9; i++) it.data[32*i +: 32] = c[i];
        it.drain = drain;
        pending_tris.push_back(it);
    endtask

    // sender: present the next pending triangle after its gap
    always @(negedge i_clk) begin
        t_tri_item it;
        logic      nv;
        nv = i_s_tvalid;
        if (i_rst_n && (!i_s_tvalid || s_fire)) begin
            nv = 1'b0;
            if (s_fire) send_gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_tris.size() > 0 &&
                         (!pending_tris[0].drain || expected_planes.size() == 0)) begin
                it = pending_tris.pop_front();
                i_s_tdata <= it.data;
                nv = 1'b1;
            end
        end
        i_s_tvalid <= nv;
    end

    // receiver: stall a random number of cycles per plane
    always @(negedge i_clk) begin
        if (m_fire) recv_stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (recv_stall > 0) begin
            recv_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_plane exp_p;
        s_fire = i_rst_n && i_s_tvalid && o_s_tready;
        m_fire = i_rst_n && o_m_tvalid && i_m_tready;
        if (s_fire) begin
            exp_p = plane_of(i_s_tdata);
            expected_planes.push_back(exp_p);
            n_sent++;
            if (exp_p.user[0]) n_degen++;
            if (exp_p.user[1]) n_sat++;
        end
        if (m_fire) begin
            if (expected_planes.size() == 0) begin
                $display("%0t: unexpected plane transfer data=%h user=%b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                exp_p = expected_planes.pop_front();
                n_checked++;
                if (o_m_tdata !== exp_p.data) begin
                    $display("%0t: tdata mismatch expected=%h actual=%h",
                             $time, exp_p.data, o_m_tdata);
                    errors++;
                end
                if (o_m_tuser !== exp_p.user) begin
                    $display("%0t: tuser mismatch expected=%b actual=%b",
                             $time, exp_p.user, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [31:0] c[9];
        logic [31:0] kk, dd;
        int          mode;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // degenerate: all zero, all equal, collinear
        c = '{default: 32'h0};
        add_tri(c, 0);
        c = '{default: 32'h7FFFFFFF};
        add_tri(c, 0);
        c = '{32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000,
              32'h30000, 32'h60000, 32'h90000};
        add_tri(c, 0);
        // unit triangles along each axis and both windings
        c = '{32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0};
        add_tri(c, 0);
        c = '{0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0};
        add_tri(c, 0);
        c = '{0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0};
        add_tri(c, 0);
        c = '{32'h50000, 32'h10000, 32'h30000, 32'h50000, 0, 32'h30000,
              32'h50000, 0, 32'h40000};
        add_tri(c, 0);
        // tiny triangle, smallest step
        c = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
        add_tri(c, 0);
        // widest spans between the coordinate extremes
        c = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
        add_tri(c, 0);
        c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        add_tri(c, 0);
        c = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h1, 32'hFFFFFFFF,
              32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        add_tri(c, 0);
        // diagonal plane far from the origin: offset clips high, then low
        dd = 32'h00100000;
        kk = 32'h7FFFFFFF - dd;
        c = '{kk, kk, kk, kk - dd, kk + dd, kk, kk, kk - dd, kk + dd};
        add_tri(c, 0);
        kk = 32'h80000000 + dd;
        c = '{kk, kk, kk, kk - dd, kk + dd, kk, kk, kk - dd, kk + dd};
        add_tri(c, 0);
        c = '{kk, kk, kk, kk + dd, kk - dd, kk, kk, kk + dd, kk - dd};
        add_tri(c, 1);

        // random triangles of differing shape, in chunks of differing idling
        for (int n = 0; n < 836; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            if (mode > 4) mode = 0;
            for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
            // now and then a repeated vertex or a collinear third one
            if ($urandom_range(0, 29) == 0) for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
            if ($urandom_range(0, 29) == 0)
                for (int i = 0; i < 3; i++) c[6+i] = 32'(2 * c[3+i] - c[i]);
            add_tri(c, n == 400);
            while (pending_tris.size() > 8) @(posedge i_clk);
        end

        while (pending_tris.size() > 0 || i_s_tvalid || expected_planes.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (expected_planes.size() > 0) begin
            $display("%0t: %0d planes never arrived", $time, expected_planes.size());
            errors++;
        end
        $display("triangles sent %0d, planes checked %0d", n_sent, n_checked);
        $display("degenerate planes %0d, clipped offsets %0d", n_degen, n_sat);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("%0t: run limit reached", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
